### hw/rtl/vldc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vldc_pkg
// Shared constants, register codes and control types of the radial
// vignette filter.
// ----------------------------------------------------------------------------
package vldc_pkg;

  // frame geometry
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 12;

  // distance ratio
  localparam int RATIO_FRAC_BITS = 16;
  localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
  localparam int QUOT_W          = RATIO_FRAC_BITS + 2;
  localparam int SQ_W            = 2 * DIM_W;
  localparam int DIV_STEPS       = RATIO_FRAC_BITS;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  // strength register, signed Q1.14
  localparam int STR_W     = 16;
  localparam int STR_FRAC  = 14;
  localparam int MAG_W     = 15;
  localparam int STR_LIMIT = 16384;

  // pixel arithmetic
  localparam int PIX_W       = 8;
  localparam int PIX_MAX     = 255;
  localparam int LIGHT_GAIN  = 230;
  localparam int OP_A_W      = 16;
  localparam int PROD_W      = OP_A_W + RATIO_W;
  localparam int RECIP_255   = 32897;
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_STRENGTH = 2'd2
  } vldc_cfg_idx_t;

  // per-lane stage enables
  typedef struct packed {
    logic mul_en;
    logic recip_en;
  } vldc_lane_ctrl_t;

endpackage

### hw/rtl/vignette_light_dark_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vignette_light_dark_corner
// Radial vignette on a raster-order BGRA pixel stream: lightens or darkens
// each pixel by its squared normalized distance from the frame centre.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid, in_stall  | blue_in, green_in, red_in, fourth_in
//  out     | out_valid, out_stall| blue_out, green_out, red_out, fourth_out,
//          |                    | frame_end
//  cfg     | cfg_write          | cfg_index, cfg_data
//
//  Each pixel passes from acceptance to the output register through the two
//  axis dividers, which retire one quotient bit per cycle (16 steps plus
//  squaring and a first step), then ratio scaling and two lane multiplies.
//  in_stall is high while a pixel is in work. The output register holds a
//  finished transaction, so the next pixel is accepted while it waits.
//  Reset clears the counters, the registers (width 1, height 1, strength 0)
//  and all handshake state.
// ----------------------------------------------------------------------------
module vignette_light_dark_corner (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [vldc_pkg::PIX_W-1:0]          blue_in,
  input  logic [vldc_pkg::PIX_W-1:0]          green_in,
  input  logic [vldc_pkg::PIX_W-1:0]          red_in,
  input  logic [vldc_pkg::PIX_W-1:0]          fourth_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [vldc_pkg::PIX_W-1:0]          blue_out,
  output logic [vldc_pkg::PIX_W-1:0]          green_out,
  output logic [vldc_pkg::PIX_W-1:0]          red_out,
  output logic [vldc_pkg::PIX_W-1:0]          fourth_out,
  output logic                                frame_end,
  input  logic                                cfg_write,
  input  logic [vldc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vldc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RATIO,
    S_MUL,
    S_RECIP,
    S_DONE
  } seq_state_t;

  localparam logic [vldc_pkg::RATIO_W-1:0] ONE =
    vldc_pkg::RATIO_W'(1) << vldc_pkg::RATIO_FRAC_BITS;
  localparam logic signed [vldc_pkg::STR_W-1:0] STR_POS =
    vldc_pkg::STR_W'(vldc_pkg::STR_LIMIT);
  localparam logic signed [vldc_pkg::STR_W-1:0] STR_NEG =
    -vldc_pkg::STR_W'(vldc_pkg::STR_LIMIT);

  seq_state_t                           state;
  logic [vldc_pkg::DIM_W-1:0]           image_width;
  logic [vldc_pkg::DIM_W-1:0]           image_height;
  logic [vldc_pkg::STR_W-1:0]           strength;
  logic [vldc_pkg::CNT_W-1:0]           column_count;
  logic [vldc_pkg::CNT_W-1:0]           row_count;

  logic [vldc_pkg::PIX_W-1:0]           pix [3];
  logic [vldc_pkg::PIX_W-1:0]           fourth;
  logic                                 last_pix;
  logic                                 lighten;
  logic [vldc_pkg::MAG_W-1:0]           mag;
  logic [vldc_pkg::RATIO_W-1:0]         s;

  logic [vldc_pkg::DIM_W-1:0]           eff_w;
  logic [vldc_pkg::DIM_W-1:0]           eff_h;
  logic signed [vldc_pkg::STR_W-1:0]    st_raw;
  logic signed [vldc_pkg::STR_W-1:0]    st_clamp;
  logic [vldc_pkg::STR_W-1:0]           st_abs;
  logic                                 last_col;
  logic                                 last_row;
  logic                                 in_take;

  logic                                 xdone;
  logic                                 ydone;
  logic [vldc_pkg::QUOT_W-1:0]          xquot;
  logic [vldc_pkg::QUOT_W-1:0]          yquot;
  logic [vldc_pkg::QUOT_W:0]            qsum;
  logic [vldc_pkg::QUOT_W-1:0]          half;
  logic [vldc_pkg::RATIO_W-1:0]         ratio;
  logic [vldc_pkg::RATIO_W+vldc_pkg::MAG_W-1:0] rs_prod;

  vldc_pkg::vldc_lane_ctrl_t            lane_ctrl;
  logic [vldc_pkg::PIX_W-1:0]           lane_y [3];

  // effective dimensions: zero acts as one, oversize clamps
  always_comb begin
    if (image_width == '0) begin
      eff_w = vldc_pkg::DIM_W'(1);
    end else if (image_width > vldc_pkg::DIM_W'(vldc_pkg::MAX_DIM)) begin
      eff_w = vldc_pkg::DIM_W'(vldc_pkg::MAX_DIM);
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = vldc_pkg::DIM_W'(1);
    end else if (image_height > vldc_pkg::DIM_W'(vldc_pkg::MAX_DIM)) begin
      eff_h = vldc_pkg::DIM_W'(vldc_pkg::MAX_DIM);
    end else begin
      eff_h = image_height;
    end
  end

  // strength clamp and magnitude
  assign st_raw = $signed(strength);
  always_comb begin
    if (st_raw > STR_POS) begin
      st_clamp = STR_POS;
    end else if (st_raw < STR_NEG) begin
      st_clamp = STR_NEG;
    end else begin
      st_clamp = st_raw;
    end
  end
  assign st_abs = st_clamp[vldc_pkg::STR_W-1] ? vldc_pkg::STR_W'(-st_clamp) :
                                                vldc_pkg::STR_W'(st_clamp);

  // end of row and frame
  assign last_col = (vldc_pkg::DIM_W'(column_count) + 1'b1) >= eff_w;
  assign last_row = (vldc_pkg::DIM_W'(row_count) + 1'b1) >= eff_h;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // axis lanes
  vldc_axis_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (in_take),
    .pos   (column_count),
    .dim   (eff_w),
    .done  (xdone),
    .quot  (xquot)
  );

  vldc_axis_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (in_take),
    .pos   (row_count),
    .dim   (eff_h),
    .done  (ydone),
    .quot  (yquot)
  );

  // merge the axes: ratio = min((rx + ry) / 2, 1.0), then scale by strength
  assign qsum    = (vldc_pkg::QUOT_W+1)'(xquot) + (vldc_pkg::QUOT_W+1)'(yquot);
  assign half    = qsum[vldc_pkg::QUOT_W:1];
  assign ratio   = (half > vldc_pkg::QUOT_W'(ONE)) ? ONE :
                   half[vldc_pkg::RATIO_W-1:0];
  assign rs_prod = (vldc_pkg::RATIO_W+vldc_pkg::MAG_W)'(ratio) *
                   (vldc_pkg::RATIO_W+vldc_pkg::MAG_W)'(mag);

  // colour lanes
  assign lane_ctrl.mul_en   = (state == S_MUL);
  assign lane_ctrl.recip_en = (state == S_RECIP);

  for (genvar c = 0; c < 3; c++) begin : g_lane
    vldc_lane u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .x       (pix[c]),
      .lighten (lighten),
      .s       (s),
      .y       (lane_y[c])
    );
  end

  // sequencer, counters, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= vldc_pkg::DIM_W'(1);
      image_height <= vldc_pkg::DIM_W'(1);
      strength     <= '0;
      column_count <= '0;
      row_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_write) begin
        case (vldc_pkg::vldc_cfg_idx_t'(cfg_index))
          vldc_pkg::CFG_WIDTH:    image_width  <= cfg_data[vldc_pkg::DIM_W-1:0];
          vldc_pkg::CFG_HEIGHT:   image_height <= cfg_data[vldc_pkg::DIM_W-1:0];
          vldc_pkg::CFG_STRENGTH: strength     <= cfg_data;
          default: ;
        endcase
      end

      // output transaction taken downstream, unless a new one replaces it
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pix[0]   <= blue_in;
            pix[1]   <= green_in;
            pix[2]   <= red_in;
            fourth   <= fourth_in;
            last_pix <= last_col && last_row;
            lighten  <= !st_clamp[vldc_pkg::STR_W-1] && (st_clamp != '0);
            mag      <= st_abs[vldc_pkg::MAG_W-1:0];
            if (last_col) begin
              column_count <= '0;
              row_count    <= last_row ? '0 : (row_count + 1'b1);
            end else begin
              column_count <= column_count + 1'b1;
            end
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (xdone && ydone) begin
            state <= S_RATIO;
          end
        end
        S_RATIO: begin
          s     <= rs_prod[vldc_pkg::STR_FRAC+vldc_pkg::RATIO_W-1:vldc_pkg::STR_FRAC];
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_RECIP;
        end
        S_RECIP: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            blue_out   <= lane_y[0];
            green_out  <= lane_y[1];
            red_out    <= lane_y[2];
            fourth_out <= fourth;
            frame_end  <= last_pix;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/vldc_axis_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vldc_axis_div
// Squared normalized distance along one axis: floor(a*a * 2^F / (d*d)),
// a = |2*pos - d|, by restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vldc_axis_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vldc_pkg::CNT_W-1:0]    pos,
  input  logic [vldc_pkg::DIM_W-1:0]    dim,
  output logic                          done,
  output logic [vldc_pkg::QUOT_W-1:0]   quot
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_INIT,
    D_STEP
  } div_state_t;

  localparam logic [vldc_pkg::QUOT_W-1:0] QUOT_SAT =
    vldc_pkg::QUOT_W'(1) << (vldc_pkg::RATIO_FRAC_BITS + 1);

  div_state_t                        state;
  logic [vldc_pkg::SQ_W-1:0]         asq;
  logic [vldc_pkg::SQ_W-2:0]         dsq;
  logic [vldc_pkg::SQ_W-3:0]         rem;
  logic [vldc_pkg::RATIO_W-1:0]      q;
  logic                              sat;
  logic [vldc_pkg::DIV_CNT_W-1:0]    step_cnt;

  logic [vldc_pkg::DIM_W-1:0]        twice;
  logic [vldc_pkg::DIM_W-1:0]        offset;
  logic [vldc_pkg::SQ_W-1:0]         asq_next;
  logic [vldc_pkg::SQ_W-1:0]         dsq_full;
  logic                              over;
  logic                              ge_init;
  logic [vldc_pkg::SQ_W-1:0]         rem_init;
  logic [vldc_pkg::SQ_W-2:0]         rem_shift;
  logic                              ge_step;
  logic [vldc_pkg::SQ_W-2:0]         rem_step;

  // distance from the centre and both squares
  assign twice    = {pos, 1'b0};
  assign offset   = (twice >= dim) ? (twice - dim) : (dim - twice);
  assign asq_next = vldc_pkg::SQ_W'(offset) * vldc_pkg::SQ_W'(offset);
  assign dsq_full = vldc_pkg::SQ_W'(dim) * vldc_pkg::SQ_W'(dim);

  // first quotient bit, and the check that the quotient reaches 2^(F+1)
  assign over     = asq >= {dsq, 1'b0};
  assign ge_init  = asq >= {1'b0, dsq};
  assign rem_init = ge_init ? (asq - {1'b0, dsq}) : asq;

  // one restoring step
  assign rem_shift = {rem, 1'b0};
  assign ge_step   = rem_shift >= dsq;
  assign rem_step  = ge_step ? (rem_shift - dsq) : rem_shift;

  assign quot = sat ? QUOT_SAT : {1'b0, q};

  // sequencer, always the same length so both axes finish together
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            asq   <= asq_next;
            dsq   <= dsq_full[vldc_pkg::SQ_W-2:0];
            state <= D_INIT;
          end
        end
        D_INIT: begin
          sat      <= over;
          rem      <= rem_init[vldc_pkg::SQ_W-3:0];
          q        <= {{(vldc_pkg::RATIO_W-1){1'b0}}, ge_init};
          step_cnt <= '0;
          state    <= D_STEP;
        end
        D_STEP: begin
          rem      <= rem_step[vldc_pkg::SQ_W-3:0];
          q        <= {q[vldc_pkg::RATIO_W-2:0], ge_step};
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == vldc_pkg::DIV_CNT_W'(vldc_pkg::DIV_STEPS - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/vldc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vldc_lane
// One colour channel: lighten toward a screen blend with 230, or darken by
// the factor 1 - s, saturated to a byte.
// ----------------------------------------------------------------------------
module vldc_lane (
  input  logic                              clk,
  input  vldc_pkg::vldc_lane_ctrl_t         ctrl,
  input  logic [vldc_pkg::PIX_W-1:0]        x,
  input  logic                              lighten,
  input  logic [vldc_pkg::RATIO_W-1:0]      s,
  output logic [vldc_pkg::PIX_W-1:0]        y
);

  localparam logic [vldc_pkg::RATIO_W-1:0] ONE =
    vldc_pkg::RATIO_W'(1) << vldc_pkg::RATIO_FRAC_BITS;

  logic [vldc_pkg::PROD_W-1:0]   prod;
  logic [vldc_pkg::RECIP_W-1:0]  recip;

  logic [vldc_pkg::PIX_W-1:0]    inv;
  logic [vldc_pkg::OP_A_W-1:0]   op_a;
  logic [vldc_pkg::RATIO_W-1:0]  op_b;
  logic [vldc_pkg::RATIO_W-1:0]  scaled;
  logic [vldc_pkg::PIX_W:0]      add;
  logic [vldc_pkg::PIX_W+1:0]    sum_l;

  // shared multiplier operands for both modes
  assign inv  = vldc_pkg::PIX_W'(vldc_pkg::PIX_MAX) - x;
  assign op_a = lighten ?
    (vldc_pkg::OP_A_W'(inv) * vldc_pkg::OP_A_W'(vldc_pkg::LIGHT_GAIN)) :
    vldc_pkg::OP_A_W'(x);
  assign op_b = lighten ? s : (ONE - s);

  // product scaled down by 2^F
  assign scaled = prod[vldc_pkg::PROD_W-1:vldc_pkg::RATIO_FRAC_BITS];

  // divide by 255 through the reciprocal
  assign add   = recip[vldc_pkg::RECIP_W-1:vldc_pkg::RECIP_SHIFT];
  assign sum_l = (vldc_pkg::PIX_W+2)'(x) + (vldc_pkg::PIX_W+2)'(add);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= vldc_pkg::PROD_W'(op_a) * vldc_pkg::PROD_W'(op_b);
    end
    if (ctrl.recip_en) begin
      recip <= vldc_pkg::RECIP_W'(scaled[vldc_pkg::OP_A_W-1:0]) *
               vldc_pkg::RECIP_W'(vldc_pkg::RECIP_255);
    end
  end

  // saturate to a byte
  always_comb begin
    if (lighten) begin
      y = (sum_l > (vldc_pkg::PIX_W+2)'(vldc_pkg::PIX_MAX)) ?
          vldc_pkg::PIX_W'(vldc_pkg::PIX_MAX) : sum_l[vldc_pkg::PIX_W-1:0];
    end else begin
      y = (scaled > vldc_pkg::RATIO_W'(vldc_pkg::PIX_MAX)) ?
          vldc_pkg::PIX_W'(vldc_pkg::PIX_MAX) : scaled[vldc_pkg::PIX_W-1:0];
    end
  end

endmodule

### tb/vldc_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vldc_pixel_checker
// Watches the pixel, result and register ports of the vignette filter. Keeps
// its own copy of the registers and the column/row position, works out the
// shaded pixel for every accepted input transaction and compares each
// accepted output transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module vldc_pixel_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [vldc_pkg::PIX_W-1:0]      blue_in,
  input  logic [vldc_pkg::PIX_W-1:0]      green_in,
  input  logic [vldc_pkg::PIX_W-1:0]      red_in,
  input  logic [vldc_pkg::PIX_W-1:0]      fourth_in,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [vldc_pkg::PIX_W-1:0]      blue_out,
  input  logic [vldc_pkg::PIX_W-1:0]      green_out,
  input  logic [vldc_pkg::PIX_W-1:0]      red_out,
  input  logic [vldc_pkg::PIX_W-1:0]      fourth_out,
  input  logic                            frame_end,
  input  logic                            cfg_write,
  input  logic [vldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vldc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_count,
  output int                              result_count,
  output int                              frame_count
);

  localparam longint unsigned UNITY    = 64'd1 << vldc_pkg::RATIO_FRAC_BITS;
  localparam longint unsigned GAIN     = vldc_pkg::LIGHT_GAIN;
  localparam longint unsigned FULL     = vldc_pkg::PIX_MAX;
  localparam int              MAX_SHOW = 10;

  typedef struct packed {
    logic [vldc_pkg::PIX_W-1:0] blue;
    logic [vldc_pkg::PIX_W-1:0] green;
    logic [vldc_pkg::PIX_W-1:0] red;
    logic [vldc_pkg::PIX_W-1:0] fourth;
    logic                       frame_end;
  } shaded_pixel_t;

  // register copies and raster position
  logic [vldc_pkg::DIM_W-1:0] width_reg;
  logic [vldc_pkg::DIM_W-1:0] height_reg;
  logic [vldc_pkg::STR_W-1:0] strength_reg;
  longint unsigned            column_pos;
  longint unsigned            row_pos;

  shaded_pixel_t expected_pixels[$];

  // zero acts as one, oversized acts as the largest frame side
  function automatic longint unsigned clamp_dim(input logic [vldc_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > vldc_pkg::MAX_DIM) return vldc_pkg::MAX_DIM;
    return v;
  endfunction

  // squared normalized distance along one axis
  function automatic longint unsigned axis_term(input longint unsigned pos,
                                                input longint unsigned dim);
    longint unsigned twice, offset;
    twice  = pos * 2;
    offset = (twice >= dim) ? twice - dim : dim - twice;
    return ((offset * offset) << vldc_pkg::RATIO_FRAC_BITS) / (dim * dim);
  endfunction

  // lighten toward the screen blend with 230, or darken by 1 - scale
  function automatic logic [vldc_pkg::PIX_W-1:0] shade_channel(
      input longint unsigned x,
      input int st,
      input longint unsigned scale);
    longint unsigned r;
    if (st > 0) r = x + (GAIN * (FULL - x) * scale) / (FULL * UNITY);
    else r = (x * (UNITY - scale)) >> vldc_pkg::RATIO_FRAC_BITS;
    if (r > FULL) r = FULL;
    return r[vldc_pkg::PIX_W-1:0];
  endfunction

  function automatic shaded_pixel_t shade_pixel(input logic [vldc_pkg::PIX_W-1:0] blue,
                                                input logic [vldc_pkg::PIX_W-1:0] green,
                                                input logic [vldc_pkg::PIX_W-1:0] red,
                                                input logic [vldc_pkg::PIX_W-1:0] fourth);
    longint unsigned w_eff, h_eff, ratio, scale, mag;
    int st;
    shaded_pixel_t res;
    w_eff = clamp_dim(width_reg);
    h_eff = clamp_dim(height_reg);
    st = int'($signed(strength_reg));
    if (st > vldc_pkg::STR_LIMIT) st = vldc_pkg::STR_LIMIT;
    if (st < -vldc_pkg::STR_LIMIT) st = -vldc_pkg::STR_LIMIT;
    mag = (st < 0) ? -st : st;
    ratio = (axis_term(column_pos, w_eff) + axis_term(row_pos, h_eff)) >> 1;
    if (ratio > UNITY) ratio = UNITY;
    scale = (ratio * mag) >> vldc_pkg::STR_FRAC;
    if (scale > UNITY) scale = UNITY;
    res.blue      = shade_channel(blue, st, scale);
    res.green     = shade_channel(green, st, scale);
    res.red       = shade_channel(red, st, scale);
    res.fourth    = fourth;
    res.frame_end = (column_pos + 1 >= w_eff) && (row_pos + 1 >= h_eff);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    shaded_pixel_t got, want;
    logic last_col, last_row;
    if (rst) begin
      width_reg    = 1;
      height_reg   = 1;
      strength_reg = 0;
      column_pos   = 0;
      row_pos      = 0;
      expected_pixels.delete();
      fail_count    <= 0;
      pending_count <= 0;
      result_count  <= 0;
      frame_count   <= 0;
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          vldc_pkg::CFG_WIDTH:    width_reg    = cfg_data[vldc_pkg::DIM_W-1:0];
          vldc_pkg::CFG_HEIGHT:   height_reg   = cfg_data[vldc_pkg::DIM_W-1:0];
          vldc_pkg::CFG_STRENGTH: strength_reg = cfg_data[vldc_pkg::STR_W-1:0];
          default: ;
        endcase
      end

      // output transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{blue_out, green_out, red_out, fourth_out, frame_end};
        result_count <= result_count + 1;
        if (frame_end === 1'b1) frame_count <= frame_count + 1;
        if (expected_pixels.size() == 0) begin
          if (fail_count < MAX_SHOW)
            $display("[%0t] unexpected result b=%0d g=%0d r=%0d f=%0d end=%0b",
                     $realtime, got.blue, got.green, got.red, got.fourth, got.frame_end);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (fail_count < MAX_SHOW)
              $display({"[%0t] mismatch: expected b=%0d g=%0d r=%0d f=%0d end=%0b, ",
                        "got b=%0d g=%0d r=%0d f=%0d end=%0b"}, $realtime,
                       want.blue, want.green, want.red, want.fourth, want.frame_end,
                       got.blue, got.green, got.red, got.fourth, got.frame_end);
            fail_count <= fail_count + 1;
          end
        end
      end

      // input transaction: predict, then advance the raster position
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(shade_pixel(blue_in, green_in, red_in, fourth_in));
        last_col = column_pos + 1 >= clamp_dim(width_reg);
        last_row = row_pos + 1 >= clamp_dim(height_reg);
        if (last_col) begin
          column_pos = 0;
          row_pos    = last_row ? 0 : row_pos + 1;
        end else begin
          column_pos = column_pos + 1;
        end
      end

      pending_count <= expected_pixels.size();
    end
  end

endmodule

### tb/tb_vignette_light_dark_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vignette_light_dark_corner
// Drives pixel streams into the radial vignette filter under a series of
// frame sizes and strengths, with random gaps on the pixel side and random
// back-pressure on the result side. Prediction and comparison live in the
// pixel checker; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_vignette_light_dark_corner;

  localparam int RANDOM_PIXELS = 650;
  localparam int DRAIN_CYCLES  = 30;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PAD_W         = vldc_pkg::CFG_DATA_W - vldc_pkg::DIM_W;

  logic                            clk;
  logic                            rst        = 1'b1;
  logic                            in_valid   = 1'b0;
  logic                            in_stall;
  logic [vldc_pkg::PIX_W-1:0]      blue_in    = '0;
  logic [vldc_pkg::PIX_W-1:0]      green_in   = '0;
  logic [vldc_pkg::PIX_W-1:0]      red_in     = '0;
  logic [vldc_pkg::PIX_W-1:0]      fourth_in  = '0;
  logic                            out_valid;
  logic                            out_stall  = 1'b0;
  logic [vldc_pkg::PIX_W-1:0]      blue_out;
  logic [vldc_pkg::PIX_W-1:0]      green_out;
  logic [vldc_pkg::PIX_W-1:0]      red_out;
  logic [vldc_pkg::PIX_W-1:0]      fourth_out;
  logic                            frame_end;
  logic                            cfg_write  = 1'b0;
  logic [vldc_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [vldc_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  int fail_count, pending_count, result_count, frame_count;
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int pixels_sent       = 0;
  int settings_count    = 0;
  int cycle_count       = 0;
  logic in_fire         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  vignette_light_dark_corner u_top (
    .clk, .rst,
    .in_valid, .in_stall, .blue_in, .green_in, .red_in, .fourth_in,
    .out_valid, .out_stall, .blue_out, .green_out, .red_out, .fourth_out, .frame_end,
    .cfg_write, .cfg_index, .cfg_data
  );

  vldc_pixel_checker u_checker (
    .clk, .rst,
    .in_valid, .in_stall, .blue_in, .green_in, .red_in, .fourth_in,
    .out_valid, .out_stall, .blue_out, .green_out, .red_out, .fourth_out, .frame_end,
    .cfg_write, .cfg_index, .cfg_data,
    .fail_count, .pending_count, .result_count, .frame_count
  );

  // acceptance seen at the rising edge, read by the driver at the falling edge
  always @(posedge clk) in_fire <= in_valid && !in_stall;

  // random back-pressure on the result side
  always @(negedge clk) out_stall <= ($urandom_range(99) < receiver_stall_pct);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one pixel transaction, with an optional idle gap in front
  task automatic send_pixel(input logic [vldc_pkg::PIX_W-1:0] blue, green, red, fourth);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct)
      gap = ($urandom_range(3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    blue_in   <= blue;
    green_in  <= green;
    red_in    <= red;
    fourth_in <= fourth;
    do @(negedge clk); while (!in_fire);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // all three registers, back to back, only once the filter is idle
  task automatic program_regs(input logic [vldc_pkg::CFG_DATA_W-1:0] width, height,
                              strength);
    in_valid <= 1'b0;
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= vldc_pkg::CFG_WIDTH;
    cfg_data  <= width;
    @(negedge clk);
    cfg_index <= vldc_pkg::CFG_HEIGHT;
    cfg_data  <= height;
    @(negedge clk);
    cfg_index <= vldc_pkg::CFG_STRENGTH;
    cfg_data  <= strength;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [vldc_pkg::PIX_W-1:0] pick_byte();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return vldc_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  // mostly small frames, some large, some zero or oversized; sometimes junk in upper bits
  function automatic logic [vldc_pkg::CFG_DATA_W-1:0] pick_dim();
    logic [vldc_pkg::CFG_DATA_W-1:0] d;
    case ($urandom_range(19))
      0:       d = '0;
      1:       d = vldc_pkg::CFG_DATA_W'($urandom_range(vldc_pkg::MAX_DIM + 1, 8191));
      2:       d = vldc_pkg::CFG_DATA_W'(vldc_pkg::MAX_DIM);
      3, 4:    d = vldc_pkg::CFG_DATA_W'($urandom_range(13, vldc_pkg::MAX_DIM));
      5:       d = vldc_pkg::CFG_DATA_W'(1);
      default: d = vldc_pkg::CFG_DATA_W'($urandom_range(1, 12));
    endcase
    if ($urandom_range(3) == 0)
      d[vldc_pkg::CFG_DATA_W-1:vldc_pkg::DIM_W] = PAD_W'($urandom_range(7));
    return d;
  endfunction

  function automatic logic [vldc_pkg::CFG_DATA_W-1:0] pick_strength();
    case ($urandom_range(9))
      0:       return vldc_pkg::CFG_DATA_W'(vldc_pkg::STR_LIMIT);
      1:       return vldc_pkg::CFG_DATA_W'(-vldc_pkg::STR_LIMIT);
      2:       return '0;
      3:       return vldc_pkg::CFG_DATA_W'($urandom_range(16'hFFFF));
      default: return vldc_pkg::CFG_DATA_W'($urandom_range(0, 2 * vldc_pkg::STR_LIMIT) -
                                            vldc_pkg::STR_LIMIT);
    endcase
  endfunction

  initial begin
    int random_sent, phase, count;
    random_sent = 0;
    phase       = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: every pixel is a one-pixel frame
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // full lighten on a 2x2 frame
    program_regs(16'd2, 16'd2, 16'h4000);
    send_pixel(8'h00, 8'hFF, 8'h80, 8'h5A);
    send_pixel(8'hFF, 8'h00, 8'h01, 8'hA5);
    send_pixel(8'h7F, 8'hFE, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF, 8'hFF);

    // full darken, zero width acts as one, oversized height as the maximum
    program_regs(16'd0, 16'h1FFF, 16'hC000);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h11);
    send_pixel(8'h80, 8'h40, 8'h20, 8'h22);
    send_pixel(8'h00, 8'hFF, 8'h01, 8'h33);

    // strength above the positive limit, oversized width, zero height
    program_regs(16'h1FFF, 16'd0, 16'h7FFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h44);
    send_pixel(8'hFF, 8'h80, 8'h10, 8'h55);
    send_pixel(8'h01, 8'hFE, 8'h7F, 8'h66);

    // strength below the negative limit
    program_regs(16'd1, 16'd1, 16'h8000);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h77);
    send_pixel(8'hAA, 8'h55, 8'hC3, 8'h88);

    // shrink the width, then the height, while the counters sit beyond them
    program_regs(16'd8, 16'd2, 16'hE000);
    repeat (6) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    program_regs(16'd3, 16'd2, 16'hE000);
    send_pixel(8'hC8, 8'h64, 8'h32, 8'h99);
    program_regs(16'd3, 16'd1, 16'h2000);
    repeat (3) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());

    // random phases, cycling through the idle and stall mixes
    while (random_sent < RANDOM_PIXELS) begin
      program_regs(pick_dim(), pick_dim(), pick_strength());
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
        default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
      endcase
      count = $urandom_range(15, 50);
      repeat (count) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      random_sent += count;
      phase++;
    end

    in_valid <= 1'b0;
    wait_drained();
    $display("Run summary: %0d pixels over %0d register settings, %0d results checked",
             pixels_sent, settings_count + 1, result_count);
    $display("Run summary: %0d frame ends seen, %0d mismatches, %0d idle/stall phases",
             frame_count, fail_count, phase);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
